FILE: sv/sljfr_pkg.sv
package sljfr_pkg;

	localparam logic [7:0]  SYNC_FIRST    = 8'hEB;
	localparam logic [7:0]  SYNC_SECOND   = 8'h50;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2,
		KIND_TIMEOUT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_SYNC = 3'b010,
		PH_RECV = 3'b100
	} phase_t;

	// Sticky timeout flag positions.
	localparam int FLAG_RECV = 0;
	localparam int FLAG_SYNC = 1;
	localparam int FLAG_IDLE = 2;

	typedef struct packed {
		logic start;
		logic stop;
		logic tick;
	} tmr_ctl_t;

endpackage

FILE: sv/sljfr_if.sv
interface sljfr_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sljfr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] command;
	logic [7:0] frame_length;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [2:0] timeout_flags;
	logic [7:0] checksum_errors;

	modport source (output valid, output kind, output command, output frame_length,
		output payload_byte, output payload_index, output timeout_flags,
		output checksum_errors, input ready);
	modport sink   (input valid, input kind, input command, input frame_length,
		input payload_byte, input payload_index, input timeout_flags,
		input checksum_errors, output ready);
endinterface

FILE: sv/sljfr_timer.sv
module sljfr_timer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  sljfr_pkg::tmr_ctl_t ctl,
	output logic              due
);

	logic [15:0] limit_q;
	logic [15:0] count_q;
	logic        running_q;

	// The next tick ends the count: a count of one or of zero both expire.
	assign due = running_q && (count_q <= 16'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sljfr_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= 1'b0;
		end else begin
			priority if (ctl.start) begin
				count_q   <= limit_q;
				running_q <= 1'b1;
			end else if (ctl.stop) begin
				running_q <= 1'b0;
			end else if (ctl.tick && running_q) begin
				if (due) begin
					count_q   <= '0;
					running_q <= 1'b0;
				end else begin
					count_q <= count_q - 16'd1;
				end
			end else begin
				running_q <= running_q;
			end
		end
	end

endmodule

FILE: sv/sync_length_xor_frame_receiver.sv
// Frame receiver for byte streams framed as 0xEB, 0x50, command, length,
// payload bytes and an XOR checksum over the payload.
// The in_ch channel carries items of two sorts: a received byte (action 0)
// or one tick of the inactivity timer (action 1). The out_ch channel gives
// at most one result item per input item: a payload byte with its index,
// a good or bad checksum verdict, or a timeout abort, each with the current
// command, length, sticky timeout flags and bad-checksum count.
// An accepted item sits in an input register until the output register is
// free or being emptied; the edge that moves it on writes its result into
// the output register, which offers it to out_ch. One item is taken every
// cycle while out_ch keeps up.
// When out_ch stalls, the output register holds its result and the input
// register holds the next item; in_ch.ready falls until the result is taken.
// Items that produce no result still wait behind a stalled output.
// The timeout length is written through cfg_we and cfg_data and takes
// effect at the next timer start; it resets to 100 ticks.
// Reset puts the receiver in idle with the timer stopped and all counts,
// flags and frame fields cleared. No clearing pass is needed.
module sync_length_xor_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	sljfr_in_if.sink    in_ch,
	sljfr_out_if.source out_ch
);

	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	sljfr_pkg::phase_t phase_q, phase_d;
	logic [8:0]  pos_q, pos_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  xor_q, xor_d;
	logic [2:0]  flags_q, flags_d;
	logic [7:0]  bad_q, bad_d;

	logic              res_valid;
	sljfr_pkg::kind_t  res_kind;
	logic [7:0]        res_pbyte;
	logic [7:0]        res_pidx;
	sljfr_pkg::tmr_ctl_t tctl, tctl_gated;
	logic              due;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_cmd_q;
	logic [7:0]  out_len_q;
	logic [7:0]  out_pbyte_q;
	logic [7:0]  out_pidx_q;
	logic [2:0]  out_flags_q;
	logic [7:0]  out_bad_q;

	// The held item moves on whenever the output register is free or being emptied.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			action_s1 <= in_ch.action;
			byte_s1   <= in_ch.rx_byte;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		len_d     = len_q;
		cmd_d     = cmd_q;
		xor_d     = xor_q;
		flags_d   = flags_q;
		bad_d     = bad_q;
		res_valid = 1'b0;
		res_kind  = sljfr_pkg::KIND_PAYLOAD;
		res_pbyte = '0;
		res_pidx  = '0;
		tctl      = '0;
		if (action_s1) begin
			tctl.tick = 1'b1;
			if (due) begin
				unique case (phase_q)
					sljfr_pkg::PH_SYNC: flags_d[sljfr_pkg::FLAG_SYNC] = 1'b1;
					sljfr_pkg::PH_RECV: flags_d[sljfr_pkg::FLAG_RECV] = 1'b1;
					default:            flags_d[sljfr_pkg::FLAG_IDLE] = 1'b1;
				endcase
				phase_d   = sljfr_pkg::PH_IDLE;
				pos_d     = '0;
				res_valid = 1'b1;
				res_kind  = sljfr_pkg::KIND_TIMEOUT;
			end
		end else begin
			unique case (phase_q)
				sljfr_pkg::PH_SYNC: begin
					if (byte_s1 == sljfr_pkg::SYNC_SECOND) begin
						phase_d    = sljfr_pkg::PH_RECV;
						pos_d      = '0;
						len_d      = '0;
						xor_d      = '0;
						tctl.start = 1'b1;
					end
				end
				sljfr_pkg::PH_RECV: begin
					priority if (pos_q == 9'd0) begin
						cmd_d      = byte_s1;
						pos_d      = 9'd1;
						tctl.start = 1'b1;
					end else if (pos_q == 9'd1) begin
						len_d      = byte_s1;
						pos_d      = 9'd2;
						tctl.start = 1'b1;
					end else if (pos_q == {1'b0, len_q} + 9'd2) begin
						if (byte_s1 == xor_q) begin
							res_kind = sljfr_pkg::KIND_GOOD;
						end else begin
							res_kind = sljfr_pkg::KIND_BAD;
							bad_d    = bad_q + 8'd1;
						end
						phase_d   = sljfr_pkg::PH_IDLE;
						pos_d     = '0;
						tctl.stop = 1'b1;
						res_valid = 1'b1;
					end else begin
						xor_d      = xor_q ^ byte_s1;
						pos_d      = pos_q + 9'd1;
						tctl.start = 1'b1;
						res_valid  = 1'b1;
						res_kind   = sljfr_pkg::KIND_PAYLOAD;
						res_pbyte  = byte_s1;
						res_pidx   = 8'(pos_q - 9'd2);
					end
				end
				default: begin
					// Idle, and any unused code, waits for the first sync byte.
					pos_d = '0;
					len_d = '0;
					if (byte_s1 == sljfr_pkg::SYNC_FIRST) begin
						phase_d    = sljfr_pkg::PH_SYNC;
						tctl.start = 1'b1;
					end else begin
						phase_d   = sljfr_pkg::PH_IDLE;
						tctl.stop = 1'b1;
					end
				end
			endcase
		end
	end

	assign tctl_gated = advance ? tctl : '0;

	sljfr_timer u_timer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.ctl      (tctl_gated),
		.due      (due)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sljfr_pkg::PH_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			cmd_q   <= '0;
			xor_q   <= '0;
			flags_q <= '0;
			bad_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			cmd_q   <= cmd_d;
			xor_q   <= xor_d;
			flags_q <= flags_d;
			bad_q   <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_q  <= res_kind;
			out_cmd_q   <= cmd_d;
			out_len_q   <= len_d;
			out_pbyte_q <= res_pbyte;
			out_pidx_q  <= res_pidx;
			out_flags_q <= flags_d;
			out_bad_q   <= bad_d;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.kind            = out_kind_q;
	assign out_ch.command         = out_cmd_q;
	assign out_ch.frame_length    = out_len_q;
	assign out_ch.payload_byte    = out_pbyte_q;
	assign out_ch.payload_index   = out_pidx_q;
	assign out_ch.timeout_flags   = out_flags_q;
	assign out_ch.checksum_errors = out_bad_q;

	a_timeout_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_kind == sljfr_pkg::KIND_TIMEOUT
		|=> phase_q == sljfr_pkg::PH_IDLE && pos_q == 9'd0)
		else $error("timeout abort did not return the receiver to idle");

	a_bad_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res_kind == sljfr_pkg::KIND_BAD
		|=> bad_q == $past(bad_q) + 8'd1)
		else $error("bad checksum did not bump the error count");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sljfr_pkg::PH_RECV |-> pos_q <= {1'b0, len_q} + 9'd2)
		else $error("byte position ran past the checksum byte");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1) && $stable(action_s1))
		else $error("stalled item in the input register was lost or changed");

endmodule
